/* src/ppt_pkg.sv */
// shared types for the trial-division prime / prime-power classifier
// no dependencies; imported by prime_and_prime_power_test
package ppt_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TEST = 5'b00010,
        ST_TDIV = 5'b00100,
        ST_PDIV = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

/* src/ppt_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// no package dependencies
module ppt_div #(
    parameter int WIDTH = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_diff;
    logic             fits;

    assign rem_sh   = {rem_reg, quot_reg[WIDTH-1]};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // shift the next dividend bit in, subtract when it fits
            rem_next  = fits ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            quot_next = {quot_reg[WIDTH-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

/* src/prime_and_prime_power_test.sv */
// trial-division classifier: prime and prime-power flags for one unsigned value
// values below 2 skip the search; otherwise trial division by each divisor up to
// the square root, then repeated division of the quotient by the smallest divisor found,
// all on the shared one-bit-per-cycle divider
// one item at a time: ready again from the edge that loads the result
// reset (aresetn, synchronous, active low) returns to idle with no result pending
module prime_and_prime_power_test #(
    parameter int WIDTH = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_is_prime,
    output logic             m_is_prime_power
);

    import ppt_pkg::*;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [WIDTH:0]   sq_reg, sq_next;
    logic             prime_reg, prime_next;
    logic             power_reg, power_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_prime_reg, out_prime_next;
    logic             out_power_reg, out_power_next;

    logic             div_start;
    logic [WIDTH-1:0] div_dividend;
    logic             div_done;
    logic [WIDTH-1:0] div_quot;
    logic [WIDTH-1:0] div_rem;

    ppt_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign div_dividend = (state_reg == ST_TEST) ? n_reg : div_quot;

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        power_next     = power_reg;
        m_valid_next   = m_valid_reg;
        out_prime_next = out_prime_reg;
        out_power_next = out_power_reg;
        div_start      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next  = s_value;
                    d_next  = WIDTH'(2);
                    sq_next = (WIDTH+1)'(4);
                    if (s_value < WIDTH'(2)) begin
                        prime_next = 1'b0;
                        power_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                // no divisor up to the square root: value is prime
                if (sq_reg > {1'b0, n_reg}) begin
                    prime_next = 1'b1;
                    power_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        // smallest divisor found, keep dividing the quotient by it
                        prime_next = 1'b0;
                        div_start  = 1'b1;
                        state_next = ST_PDIV;
                    end else begin
                        d_next     = d_reg + WIDTH'(1);
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        state_next = ST_TEST;
                    end
                end
            end
            ST_PDIV: begin
                if (div_done) begin
                    if (div_rem != '0) begin
                        power_next = 1'b0;
                        state_next = ST_DONE;
                    end else if (div_quot == WIDTH'(1)) begin
                        power_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_prime_next = prime_reg;
                    out_power_next = power_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        power_reg     <= power_next;
        out_prime_reg <= out_prime_next;
        out_power_reg <= out_power_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_is_prime       = out_prime_reg;
    assign m_is_prime_power = out_power_reg;

    // every prime is also a prime power
    a_prime_is_power: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_is_prime || m_is_prime_power))
        else $error("prime flagged without prime-power flag");

    // running square tracks the trial divisor
    a_square_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST) |->
            ((2*WIDTH)'(d_reg) * (2*WIDTH)'(d_reg) == (2*WIDTH)'(sq_reg)))
        else $error("running square out of step with divisor");

    // divider finishes only while the sequencer waits on it
    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_TDIV || state_reg == ST_PDIV))
        else $error("divider result arrived outside a wait state");

    // trial divisor never drops below two during a search
    a_divisor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST || state_reg == ST_TDIV || state_reg == ST_PDIV)
            |-> (d_reg >= WIDTH'(2)))
        else $error("trial divisor below two");

endmodule
